// File: hdl/feature_row_accumulator_update_core_assert.svh
// Assertion macros for the checker file of the accumulator update block.
// Plain text macros only; users include this file by its bare name.
`ifndef FEATURE_ROW_ACCUMULATOR_UPDATE_CORE_ASSERT_SVH
`define FEATURE_ROW_ACCUMULATOR_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define FRAU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frau check failed: same-cycle implication");

// Next-cycle implication, held off while reset is high.
`define FRAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frau check failed: next-cycle implication");

// Delayed implication, held off while reset is high.
`define FRAU_ASSERT_DELAY3(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error("frau check failed: delayed implication");

`endif

// File: hdl/frau_pkg.sv
// Shared field widths and request codes for the accumulator update block.
// No dependencies.
`default_nettype none

package frau_pkg;

  localparam int TYPE_W = 3;
  localparam int FEAT_W = 10;
  localparam int HID_W  = 8;
  localparam int WORD_W = 16;

  localparam logic [TYPE_W-1:0] REQ_WRITE_WEIGHT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE_ACC    = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_SUB_ROW      = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_ADD_ROW      = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_READ_ACC     = 3'd4;

endpackage

`default_nettype wire

// File: hdl/frau_req_if.sv
// Request channel: valid/ready handshake carrying one request beat.
// Depends on frau_pkg for field widths.
`default_nettype none

interface frau_req_if import frau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic [FEAT_W-1:0]        feature_index;
  logic [HID_W-1:0]         hidden_index;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, req_type, feature_index, hidden_index, value, input ready);
  modport sink   (input valid, req_type, feature_index, hidden_index, value, output ready);
endinterface

`default_nettype wire

// File: hdl/frau_rsp_if.sv
// Response channel: valid/ready handshake carrying one read-result beat.
// Depends on frau_pkg for field widths.
`default_nettype none

interface frau_rsp_if import frau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [HID_W-1:0]         read_index;

  modport source (output valid, read_value, read_index, input ready);
  modport sink   (input valid, read_value, read_index, output ready);
endinterface

`default_nettype wire

// File: hdl/frau_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module frau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/feature_row_accumulator_update_core.sv
// Feature-row accumulator update. One request is taken at a time. A weight or
// accumulator word write passes through S_EXEC before ready returns. A row add
// or subtract passes through S_EXEC and S_RUN: one LANES-wide add/subtract unit
// walks the accumulator one chunk a cycle, reading each chunk and its weight
// chunk, then writing the sum back in the next cycle. A read passes through
// S_EXEC and S_RDATA to a registered result; ready stays low while a result
// waits. Memories are split into LANES banks; element h lives in bank h % LANES
// at row h / LANES. Neither memory is cleared: words must be written before use.
`default_nettype none

module feature_row_accumulator_update_core import frau_pkg::*; #(
  parameter int HIDDEN_SIZE   = 256,
  parameter int FEATURE_COUNT = 1024,
  parameter int LANES         = 16
) (
  input wire logic clk,
  input wire logic rst,
  frau_req_if.sink   req,
  frau_rsp_if.source rsp
);

  localparam int CHUNKS = (HIDDEN_SIZE + LANES - 1) / LANES;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNTW   = $clog2(CHUNKS + 1);
  localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int WDEPTH = FEATURE_COUNT * CHUNKS;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int HCOUNT = 2 ** HID_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_RUN   = 4'b0100,
    S_RDATA = 4'b1000
  } state_t;

  state_t state, state_next;

  // index split tables, built at elaboration
  logic [CW-1:0] div_tab [HCOUNT];
  logic [LW-1:0] mod_tab [HCOUNT];

  for (genvar g = 0; g < HCOUNT; g++) begin : g_tab
    assign div_tab[g] = CW'(g / LANES);
    assign mod_tab[g] = LW'(g % LANES);
  end

  logic [TYPE_W-1:0] req_q;
  logic [HID_W-1:0]  hid_q;
  logic [WORD_W-1:0] val_q;
  logic [CW-1:0]     ld_q;
  logic [LW-1:0]     lm_q;
  logic [WAW-1:0]    row_base_q;
  logic              hid_ok_q;
  logic              feat_ok_q;

  logic [CNTW-1:0]   issue_cnt;
  logic              wb_valid;
  logic [CW-1:0]     wb_chunk;

  logic              out_valid;
  logic [WORD_W-1:0] out_value;
  logic [HID_W-1:0]  out_index;

  logic              accept;
  logic              issue_go;
  logic              run_done;
  logic              exec_wacc;
  logic              exec_wwt;

  logic [CW-1:0]     acc_raddr;
  logic [CW-1:0]     acc_waddr;
  logic [WAW-1:0]    wt_raddr;
  logic [WAW-1:0]    wt_waddr;
  logic [WORD_W-1:0] acc_rd   [LANES];
  logic [WORD_W-1:0] wt_rd    [LANES];
  logic [WORD_W-1:0] acc_wd   [LANES];
  logic              acc_we   [LANES];
  logic              wt_we    [LANES];

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign accept    = req.valid && req.ready;

  assign issue_go  = (state == S_RUN) && (issue_cnt != CNTW'(CHUNKS));
  assign run_done  = (state == S_RUN) && wb_valid && (wb_chunk == CW'(CHUNKS - 1));
  assign exec_wacc = (state == S_EXEC) && (req_q == REQ_WRITE_ACC) && hid_ok_q;
  assign exec_wwt  = (state == S_EXEC) && (req_q == REQ_WRITE_WEIGHT) && hid_ok_q && feat_ok_q;

  assign acc_raddr = (state == S_RUN) ? issue_cnt[CW-1:0] : ld_q;
  assign acc_waddr = wb_valid ? wb_chunk : ld_q;
  assign wt_raddr  = row_base_q + WAW'(issue_cnt[CW-1:0]);
  assign wt_waddr  = row_base_q + WAW'(ld_q);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if ((req_q == REQ_SUB_ROW || req_q == REQ_ADD_ROW) && feat_ok_q) begin
          state_next = S_RUN;
        end else if (req_q == REQ_READ_ACC) begin
          state_next = S_RDATA;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (run_done) state_next = S_IDLE;
      end
      S_RDATA: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wb_valid  <= 1'b0;
      out_valid <= 1'b0;
      issue_cnt <= '0;
    end else begin
      state    <= state_next;
      wb_valid <= issue_go;
      if (state == S_EXEC) begin
        issue_cnt <= '0;
      end else if (issue_go) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (state == S_RDATA) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req.req_type;
      hid_q      <= req.hidden_index;
      val_q      <= req.value;
      ld_q       <= div_tab[req.hidden_index];
      lm_q       <= mod_tab[req.hidden_index];
      hid_ok_q   <= int'(req.hidden_index) < HIDDEN_SIZE;
      feat_ok_q  <= int'(req.feature_index) < FEATURE_COUNT;
      row_base_q <= WAW'(int'(req.feature_index) * CHUNKS);
    end
    wb_chunk <= issue_cnt[CW-1:0];
    if (state == S_RDATA) begin
      out_value <= hid_ok_q ? acc_rd[lm_q] : '0;
      out_index <= hid_q;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // shared add/subtract lane, wraps modulo 2^16
    always_comb begin
      if (wb_valid) begin
        acc_wd[l] = (req_q == REQ_SUB_ROW) ? acc_rd[l] - wt_rd[l] : acc_rd[l] + wt_rd[l];
      end else begin
        acc_wd[l] = val_q;
      end
    end

    assign acc_we[l] = wb_valid || (exec_wacc && (lm_q == LW'(l)));
    assign wt_we[l]  = exec_wwt && (lm_q == LW'(l));

    frau_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CHUNKS)
    ) u_acc_bank (
      .clk   (clk),
      .we    (acc_we[l]),
      .waddr (acc_waddr),
      .wdata (acc_wd[l]),
      .raddr (acc_raddr),
      .rdata (acc_rd[l])
    );

    frau_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WDEPTH)
    ) u_wt_bank (
      .clk   (clk),
      .we    (wt_we[l]),
      .waddr (wt_waddr),
      .wdata (val_q),
      .raddr (wt_raddr),
      .rdata (wt_rd[l])
    );
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.read_index = out_index;

endmodule

`default_nettype wire

// File: hdl/frau_checker.sv
// Port-level checks for the accumulator update block, bound to its top level.
// Depends on frau_pkg and the assertion macro header.
`default_nettype none

`include "feature_row_accumulator_update_core_assert.svh"

module frau_checker import frau_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic [TYPE_W-1:0] req_type,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [WORD_W-1:0] read_value,
  input wire logic [HID_W-1:0]  read_index
);

  // a stalled result beat holds
  `FRAU_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value) && $stable(read_index))

  // no new request while a result waits
  `FRAU_ASSERT_IMPLY(a_busy_on_rsp, clk, rst, rsp_valid, !req_ready)

  // one request at a time
  `FRAU_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // an accepted read later returns a result beat
  `FRAU_ASSERT_DELAY3(a_read_latency, clk, rst, req_valid && req_ready && (req_type == REQ_READ_ACC), rsp_valid)

endmodule

bind feature_row_accumulator_update_core frau_checker u_frau_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_type   (req.req_type),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_value (rsp.read_value),
  .read_index (rsp.read_index)
);

`default_nettype wire
